// ===== rtl/ccrv_pkg.sv =====
// Shared constants, types and the arctangent table of the circular CORDIC block.
package ccrv_pkg;

   localparam int ITERATIONS_DEF   = 16;
   localparam int DATA_WIDTH_DEF   = 16;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int SCALE_STAGES_DEF = 4;

   // angle accumulator always holds Q3.13 within +-(pi/2 + sum of table)
   localparam int ACC_WIDTH = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 4;
   localparam int USED_WIDTH      = 3;
   localparam int SHIFT_WIDTH     = 4;
   localparam int SHIFT_REGS      = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STAGES_USED = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_A     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_B     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_C     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_D     = 3'd4;

   localparam logic [USED_WIDTH-1:0]  STAGES_USED_RESET = 3'd4;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_A_RESET     = 4'd2;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_B_RESET     = 4'd3;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_C_RESET     = 4'd4;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_D_RESET     = 4'd7;

   localparam logic signed [ACC_WIDTH-1:0] HALF_PI = 16'sd12868;

   typedef struct packed {
      logic valid;
      logic vec;
   } ctrl_type;

   // round(atan(2^-idx) * 2^13)
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input int idx);
      logic signed [ACC_WIDTH-1:0] val;
      case (idx)
         0:       val = 16'sd6434;
         1:       val = 16'sd3798;
         2:       val = 16'sd2007;
         3:       val = 16'sd1019;
         4:       val = 16'sd511;
         5:       val = 16'sd256;
         6:       val = 16'sd128;
         7:       val = 16'sd64;
         8:       val = 16'sd32;
         9:       val = 16'sd16;
         10:      val = 16'sd8;
         11:      val = 16'sd4;
         12:      val = 16'sd2;
         13:      val = 16'sd1;
         default: val = 16'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/ccrv_if.sv =====
// Valid/ready channel interfaces: request, response and register write.
interface ccrv_req_if #(
   parameter int DATA_WIDTH  = ccrv_pkg::DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ccrv_pkg::ANGLE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic signed [ANGLE_WIDTH-1:0] theta;
   logic signed [DATA_WIDTH-1:0]  x_in;
   logic signed [DATA_WIDTH-1:0]  y_in;

   modport source (output valid, command, theta, x_in, y_in, input ready);
   modport sink   (input valid, command, theta, x_in, y_in, output ready);
endinterface

interface ccrv_rsp_if #(
   parameter int DATA_WIDTH  = ccrv_pkg::DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ccrv_pkg::ANGLE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] phase;
   logic signed [DATA_WIDTH-1:0]  x_out;
   logic signed [DATA_WIDTH-1:0]  y_out;

   modport source (output valid, phase, x_out, y_out, input ready);
   modport sink   (input valid, phase, x_out, y_out, output ready);
endinterface

interface ccrv_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ccrv_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ccrv_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ccrv_rot_cell.sv =====
// One CORDIC micro-rotation cell with a fixed shift and table entry.
module ccrv_rot_cell #(
   parameter int STEP        = 0,
   parameter int DATA_WIDTH  = ccrv_pkg::DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ccrv_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  ccrv_pkg::ctrl_type                     up_ctrl,
   input  logic signed [DATA_WIDTH:0]             up_x,
   input  logic signed [DATA_WIDTH:0]             up_y,
   input  logic signed [ccrv_pkg::ACC_WIDTH-1:0]  up_acc,
   input  logic signed [ANGLE_WIDTH-1:0]          up_target,
   output ccrv_pkg::ctrl_type                     dn_ctrl,
   output logic signed [DATA_WIDTH:0]             dn_x,
   output logic signed [DATA_WIDTH:0]             dn_y,
   output logic signed [ccrv_pkg::ACC_WIDTH-1:0]  dn_acc,
   output logic signed [ANGLE_WIDTH-1:0]          dn_target
);
   localparam int CW = (ANGLE_WIDTH > ccrv_pkg::ACC_WIDTH) ? ANGLE_WIDTH : ccrv_pkg::ACC_WIDTH;
   localparam logic signed [ccrv_pkg::ACC_WIDTH-1:0] ATAN = ccrv_pkg::atan_entry(STEP);

   ccrv_pkg::ctrl_type                    ctrl_ff;
   logic signed [DATA_WIDTH:0]            x_ff, y_ff, x_in, y_in;
   logic signed [ccrv_pkg::ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ANGLE_WIDTH-1:0]         target_ff;
   logic signed [CW-1:0]                  acc_ext, target_ext;
   logic signed [DATA_WIDTH:0]            xs, ys;
   logic                                  ccw;

   always_comb begin
      acc_ext    = CW'(up_acc);
      target_ext = CW'(up_target);
      ccw        = up_ctrl.vec ? up_y[DATA_WIDTH] : (acc_ext < target_ext);
      xs         = up_y >>> STEP;
      ys         = up_x >>> STEP;
      if (ccw) begin
         x_in   = up_x - xs;
         y_in   = up_y + ys;
         acc_in = up_acc + ATAN;
      end else begin
         x_in   = up_x + xs;
         y_in   = up_y - ys;
         acc_in = up_acc - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         acc_ff    <= acc_in;
         target_ff <= up_target;
      end
   end

   assign dn_ctrl   = ctrl_ff;
   assign dn_x      = x_ff;
   assign dn_y      = y_ff;
   assign dn_acc    = acc_ff;
   assign dn_target = target_ff;

endmodule

// ===== rtl/ccrv_gain_cell.sv =====
// One gain-correction cell: v - (v >>> shift) on x and y when enabled.
module ccrv_gain_cell #(
   parameter int DATA_WIDTH = ccrv_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   apply,
   input  logic [ccrv_pkg::SHIFT_WIDTH-1:0]       shift,
   input  ccrv_pkg::ctrl_type                     up_ctrl,
   input  logic signed [DATA_WIDTH:0]             up_x,
   input  logic signed [DATA_WIDTH:0]             up_y,
   input  logic signed [ccrv_pkg::ACC_WIDTH-1:0]  up_acc,
   output ccrv_pkg::ctrl_type                     dn_ctrl,
   output logic signed [DATA_WIDTH:0]             dn_x,
   output logic signed [DATA_WIDTH:0]             dn_y,
   output logic signed [ccrv_pkg::ACC_WIDTH-1:0]  dn_acc
);
   ccrv_pkg::ctrl_type                    ctrl_ff;
   logic signed [DATA_WIDTH:0]            x_ff, y_ff, x_in, y_in;
   logic signed [ccrv_pkg::ACC_WIDTH-1:0] acc_ff;

   always_comb begin
      if (apply) begin
         x_in = up_x - (up_x >>> shift);
         y_in = up_y - (up_y >>> shift);
      end else begin
         x_in = up_x;
         y_in = up_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= up_acc;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_acc  = acc_ff;

endmodule

// ===== rtl/circular_cordic_rotate_vector.sv =====
// Top level of the circular CORDIC: pre-rotation, rotation cells, gain cells, output.
//
// Usage:
//   req_ch carries one beat per problem: command (0 rotate toward theta,
//   1 vector x/y onto the x axis), theta (Q3.13), x_in and y_in.
//   rsp_ch returns one beat per request, in order: phase (negated
//   accumulated angle, Q3.13), x_out and y_out, gain-corrected and saturated.
//   csr_ch writes the gain-correction registers (index 0 stage count,
//   1..4 shift amounts); it is always ready. Write only while idle.
// Timing:
//   The row holds one pre-rotation stage, one cell per micro-rotation
//   (ITERATIONS), one cell per gain stage (SCALE_STAGES) and the output
//   register. One beat per cycle is accepted when the output is not
//   stalled; the cell row is a straight pipeline.
// Stall: while rsp_ch holds an untaken beat, the whole row freezes and
//   req_ch.ready drops; no beat is lost or repeated.
// Reset: synchronous; clears all valid bits and loads the register defaults.
module circular_cordic_rotate_vector #(
   parameter int ITERATIONS   = ccrv_pkg::ITERATIONS_DEF,
   parameter int DATA_WIDTH   = ccrv_pkg::DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ccrv_pkg::ANGLE_WIDTH_DEF,
   parameter int SCALE_STAGES = ccrv_pkg::SCALE_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ccrv_req_if.sink    req_ch,
   ccrv_rsp_if.source  rsp_ch,
   ccrv_csr_if.sink    csr_ch
);
   localparam int AW = ccrv_pkg::ACC_WIDTH;
   localparam int CW = (ANGLE_WIDTH > AW) ? ANGLE_WIDTH : AW;
   localparam int NW = (ANGLE_WIDTH > AW + 1) ? ANGLE_WIDTH : AW + 1;
   localparam logic signed [CW-1:0] HALF_PI_EXT = CW'(ccrv_pkg::HALF_PI);

   // ---------------- registers ----------------
   logic [ccrv_pkg::USED_WIDTH-1:0]  used_ff;
   logic [ccrv_pkg::SHIFT_WIDTH-1:0] shift_ff [ccrv_pkg::SHIFT_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= ccrv_pkg::STAGES_USED_RESET;
         shift_ff[0] <= ccrv_pkg::SHIFT_A_RESET;
         shift_ff[1] <= ccrv_pkg::SHIFT_B_RESET;
         shift_ff[2] <= ccrv_pkg::SHIFT_C_RESET;
         shift_ff[3] <= ccrv_pkg::SHIFT_D_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ccrv_pkg::CSR_STAGES_USED: used_ff     <= csr_ch.data[ccrv_pkg::USED_WIDTH-1:0];
            ccrv_pkg::CSR_SHIFT_A:     shift_ff[0] <= csr_ch.data;
            ccrv_pkg::CSR_SHIFT_B:     shift_ff[1] <= csr_ch.data;
            ccrv_pkg::CSR_SHIFT_C:     shift_ff[2] <= csr_ch.data;
            ccrv_pkg::CSR_SHIFT_D:     shift_ff[3] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // ---------------- flow control ----------------
   logic rsp_valid_ff;
   logic en;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // ---------------- pre-rotation ----------------
   ccrv_pkg::ctrl_type            rot_ctrl   [ITERATIONS+1];
   logic signed [DATA_WIDTH:0]    rot_x      [ITERATIONS+1];
   logic signed [DATA_WIDTH:0]    rot_y      [ITERATIONS+1];
   logic signed [AW-1:0]          rot_acc    [ITERATIONS+1];
   logic signed [ANGLE_WIDTH-1:0] rot_target [ITERATIONS+1];

   ccrv_pkg::ctrl_type            pre_ctrl_ff, pre_ctrl_in;
   logic signed [DATA_WIDTH:0]    pre_x_ff, pre_y_ff, pre_x_in, pre_y_in;
   logic signed [AW-1:0]          pre_acc_ff, pre_acc_in;
   logic signed [ANGLE_WIDTH-1:0] pre_target_ff;
   logic signed [CW-1:0]          tgt_ext;
   logic signed [DATA_WIDTH:0]    x0, y0;
   logic                          x_neg, y_pos, turn_cw, turn_ccw;

   always_comb begin
      tgt_ext = CW'(req_ch.theta);
      x0      = (DATA_WIDTH+1)'(req_ch.x_in);
      y0      = (DATA_WIDTH+1)'(req_ch.y_in);
      x_neg   = x0[DATA_WIDTH];
      y_pos   = !y0[DATA_WIDTH] && (|y0);
      if (req_ch.command) begin
         turn_cw  = x_neg && y_pos;
         turn_ccw = x_neg;
      end else begin
         turn_cw  = tgt_ext < -HALF_PI_EXT;
         turn_ccw = tgt_ext > HALF_PI_EXT;
      end
      if (turn_cw) begin
         pre_acc_in = -ccrv_pkg::HALF_PI;
         pre_x_in   = y0;
         pre_y_in   = -x0;
      end else if (turn_ccw) begin
         pre_acc_in = ccrv_pkg::HALF_PI;
         pre_x_in   = -y0;
         pre_y_in   = x0;
      end else begin
         pre_acc_in = '0;
         pre_x_in   = x0;
         pre_y_in   = y0;
      end
      pre_ctrl_in.valid = req_ch.valid;
      pre_ctrl_in.vec   = req_ch.command;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ctrl_ff <= '0;
      end else if (en) begin
         pre_ctrl_ff <= pre_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_x_ff      <= pre_x_in;
         pre_y_ff      <= pre_y_in;
         pre_acc_ff    <= pre_acc_in;
         pre_target_ff <= req_ch.theta;
      end
   end

   assign rot_ctrl[0]   = pre_ctrl_ff;
   assign rot_x[0]      = pre_x_ff;
   assign rot_y[0]      = pre_y_ff;
   assign rot_acc[0]    = pre_acc_ff;
   assign rot_target[0] = pre_target_ff;

   // ---------------- micro-rotation cells ----------------
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      ccrv_rot_cell #(
         .STEP        (i),
         .DATA_WIDTH  (DATA_WIDTH),
         .ANGLE_WIDTH (ANGLE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_ctrl   (rot_ctrl[i]),
         .up_x      (rot_x[i]),
         .up_y      (rot_y[i]),
         .up_acc    (rot_acc[i]),
         .up_target (rot_target[i]),
         .dn_ctrl   (rot_ctrl[i+1]),
         .dn_x      (rot_x[i+1]),
         .dn_y      (rot_y[i+1]),
         .dn_acc    (rot_acc[i+1]),
         .dn_target (rot_target[i+1])
      );
   end

   // ---------------- gain-correction cells ----------------
   ccrv_pkg::ctrl_type         gain_ctrl [SCALE_STAGES+1];
   logic signed [DATA_WIDTH:0] gain_x    [SCALE_STAGES+1];
   logic signed [DATA_WIDTH:0] gain_y    [SCALE_STAGES+1];
   logic signed [AW-1:0]       gain_acc  [SCALE_STAGES+1];

   assign gain_ctrl[0] = rot_ctrl[ITERATIONS];
   assign gain_x[0]    = rot_x[ITERATIONS];
   assign gain_y[0]    = rot_y[ITERATIONS];
   assign gain_acc[0]  = rot_acc[ITERATIONS];

   for (genvar k = 0; k < SCALE_STAGES; k++) begin : g_gain
      logic stage_on;
      // a count above SCALE_STAGES still enables every stage present
      assign stage_on = used_ff > ccrv_pkg::USED_WIDTH'(k);

      ccrv_gain_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .apply   (stage_on),
         .shift   (shift_ff[k]),
         .up_ctrl (gain_ctrl[k]),
         .up_x    (gain_x[k]),
         .up_y    (gain_y[k]),
         .up_acc  (gain_acc[k]),
         .dn_ctrl (gain_ctrl[k+1]),
         .dn_x    (gain_x[k+1]),
         .dn_y    (gain_y[k+1]),
         .dn_acc  (gain_acc[k+1])
      );
   end

   // ---------------- saturation and output register ----------------
   logic signed [NW-1:0]          neg_acc;
   logic signed [ANGLE_WIDTH-1:0] angle_sat;
   logic signed [DATA_WIDTH:0]    x_last, y_last;
   logic signed [DATA_WIDTH-1:0]  x_sat, y_sat;
   logic signed [ANGLE_WIDTH-1:0] phase_ff;
   logic signed [DATA_WIDTH-1:0]  x_out_ff, y_out_ff;
   logic [NW-ANGLE_WIDTH:0]       neg_top;

   always_comb begin
      neg_acc = -(NW'(gain_acc[SCALE_STAGES]));
      neg_top = neg_acc[NW-1:ANGLE_WIDTH-1];
      if ((&neg_top) || !(|neg_top)) begin
         angle_sat = neg_acc[ANGLE_WIDTH-1:0];
      end else if (neg_acc[NW-1]) begin
         angle_sat = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      end else begin
         angle_sat = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      end

      x_last = gain_x[SCALE_STAGES];
      y_last = gain_y[SCALE_STAGES];
      if (x_last[DATA_WIDTH] == x_last[DATA_WIDTH-1]) begin
         x_sat = x_last[DATA_WIDTH-1:0];
      end else begin
         x_sat = {x_last[DATA_WIDTH], {(DATA_WIDTH-1){!x_last[DATA_WIDTH]}}};
      end
      if (y_last[DATA_WIDTH] == y_last[DATA_WIDTH-1]) begin
         y_sat = y_last[DATA_WIDTH-1:0];
      end else begin
         y_sat = {y_last[DATA_WIDTH], {(DATA_WIDTH-1){!y_last[DATA_WIDTH]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= gain_ctrl[SCALE_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= angle_sat;
         x_out_ff <= x_sat;
         y_out_ff <= y_sat;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.phase = phase_ff;
   assign rsp_ch.x_out = x_out_ff;
   assign rsp_ch.y_out = y_out_ff;

   // ---------------- assertions ----------------
   logic [ITERATIONS:0] rot_valid_vec;
   always_comb begin
      for (int n = 0; n <= ITERATIONS; n++) begin
         rot_valid_vec[n] = rot_ctrl[n].valid;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output valid not cleared by reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> rot_ctrl[0].valid)
      else $error("accepted beat missing from pre-rotation stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(rot_valid_vec))
      else $error("rotation cells moved during a stall");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(gain_ctrl[SCALE_STAGES].valid))
      else $error("response beat without an item in the last cell");

endmodule
